>>> hdl/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// shared types and constants of the sparse coordinate table
// ----------------------------------------------------------------------------
package scp_pkg;

    // parameter defaults
    localparam int DEF_CAPACITY   = 128;
    localparam int DEF_COORD_BITS = 8;
    localparam int DEF_VALUE_BITS = 64;

    // fixed port widths
    localparam int IN_COORD_W = 8;
    localparam int IN_VALUE_W = 64;
    localparam int LIMIT_W    = 9;
    localparam int REQ_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_LIMIT    = 2'd0,
        CFG_COLUMN_LIMIT = 2'd1
    } t_cfg_reg;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_LOOKUP = 2'd2
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_UPDATED = 3'd1,
        ST_REMOVED = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_FULL    = 3'd4,
        ST_BOUNDS  = 3'd5,
        ST_FOUND   = 3'd6,
        ST_EMPTY   = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_SHIFT = 2'd2
    } t_state;

    typedef struct packed {
        logic    done;
        t_status status;
    } t_resp;

endpackage

>>> hdl/sparse_coordinate_table.sv
// ----------------------------------------------------------------------------
// sparse_coordinate_table
// coordinate-list store of occupied grid cells with insert, remove, lookup
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                     payload
// request   in         start high, busy low          i_req_type, i_row_coord,
//                                                    i_column_coord, i_cell_value
// result    out        o_done strobe, one cycle      o_status, o_found_value,
//                                                    o_entry_count
// config    in         i_cfg_valid and o_cfg_ready   i_cfg_index, i_cfg_data
//
// an out-of-bounds request returns its result in the cycle after the transfer
// insert and lookup scan the packed entries through the single read port of
// the entry memory, one entry a cycle
// remove scans up to the match, then moves each later entry down one slot,
// one entry a cycle on the same port
// synchronous active-low reset empties the table and restores both limits
// to 16; the memory contents are not cleared, slots at or above the count
// are never read; results cannot be stalled by the receiver
// ----------------------------------------------------------------------------
module sparse_coordinate_table #(
    parameter int CAPACITY   = scp_pkg::DEF_CAPACITY,
    parameter int COORD_BITS = scp_pkg::DEF_COORD_BITS,
    parameter int VALUE_BITS = scp_pkg::DEF_VALUE_BITS,
    localparam int CW        = $clog2(CAPACITY + 1)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              start,
    output logic                              busy,
    input  logic [scp_pkg::REQ_W-1:0]         i_req_type,
    input  logic [scp_pkg::IN_COORD_W-1:0]    i_row_coord,
    input  logic [scp_pkg::IN_COORD_W-1:0]    i_column_coord,
    input  logic [scp_pkg::IN_VALUE_W-1:0]    i_cell_value,
    // result channel
    output logic                              o_done,
    output logic [scp_pkg::STATUS_W-1:0]      o_status,
    output logic [scp_pkg::IN_VALUE_W-1:0]    o_found_value,
    output logic [CW-1:0]                     o_entry_count,
    // configuration channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [scp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [scp_pkg::LIMIT_W-1:0]       i_cfg_data
);

    // coordinates are taken in their low bits, never wider than the port
    localparam int KW = (COORD_BITS < scp_pkg::IN_COORD_W) ? COORD_BITS
                                                           : scp_pkg::IN_COORD_W;
    localparam int VW = VALUE_BITS;
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int DW = 2 * KW + VW;

    logic [scp_pkg::LIMIT_W-1:0] r_row_limit;
    logic [scp_pkg::LIMIT_W-1:0] r_column_limit;

    logic [KW-1:0]  w_row;
    logic [KW-1:0]  w_col;
    logic [VW-1:0]  w_val;
    logic           w_oob;
    scp_pkg::t_resp w_resp;
    logic [VW-1:0]  w_found;

    logic          w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [DW-1:0] w_rd_data;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [DW-1:0] w_wr_data;

    // limit registers, written any time the channel offers a transfer naming one of them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_limit    <= scp_pkg::LIMIT_RESET;
            r_column_limit <= scp_pkg::LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == scp_pkg::CFG_ROW_LIMIT) begin
                r_row_limit <= i_cfg_data;
            end
            if (i_cfg_index == scp_pkg::CFG_COLUMN_LIMIT) begin
                r_column_limit <= i_cfg_data;
            end
        end
    end

    assign o_cfg_ready = 1'b1;

    // request decode and bounds check ahead of any search
    assign w_row = i_row_coord[KW-1:0];
    assign w_col = i_column_coord[KW-1:0];
    assign w_val = i_cell_value[VW-1:0];
    assign w_oob = (scp_pkg::LIMIT_W'(w_row) >= r_row_limit)
                || (scp_pkg::LIMIT_W'(w_col) >= r_column_limit);

    scp_ctrl #(
        .CAPACITY (CAPACITY),
        .KW       (KW),
        .VW       (VW),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_busy    (busy),
        .i_op      (i_req_type),
        .i_row     (w_row),
        .i_col     (w_col),
        .i_val     (w_val),
        .i_oob     (w_oob),
        .o_resp    (w_resp),
        .o_found   (w_found),
        .o_count   (o_entry_count),
        .o_rd_en   (w_rd_en),
        .o_rd_addr (w_rd_addr),
        .i_rd_data (w_rd_data),
        .o_wr_en   (w_wr_en),
        .o_wr_addr (w_wr_addr),
        .o_wr_data (w_wr_data)
    );

    // entry store: {row, column, value} per slot
    scp_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_done        = w_resp.done;
    assign o_status      = w_resp.status;
    assign o_found_value = scp_pkg::IN_VALUE_W'(w_found);

    // count never exceeds the table size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_entry_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // the count only moves together with a result
    a_count_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_entry_count != $past(o_entry_count)) |-> o_done)
        else $error("entry count changed without a result");

    // an added entry grows the table by exactly one
    a_added_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == scp_pkg::ST_ADDED)
            |-> (o_entry_count == $past(o_entry_count) + CW'(1)))
        else $error("added entry did not grow the count by one");

    // a value is only returned by a successful lookup
    a_value_on_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != scp_pkg::ST_FOUND) |-> (o_found_value == '0))
        else $error("value returned without a hit");

endmodule

>>> hdl/scp_mem.sv
// ----------------------------------------------------------------------------
// scp_mem
// entry store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module scp_mem #(
    parameter int DEPTH = scp_pkg::DEF_CAPACITY,
    parameter int AW    = 7,
    parameter int DW    = 80
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/scp_ctrl.sv
// ----------------------------------------------------------------------------
// scp_ctrl
// request sequencer: pipelined scan, in-place update, append, shift-down
// ----------------------------------------------------------------------------
module scp_ctrl #(
    parameter int CAPACITY = scp_pkg::DEF_CAPACITY,
    parameter int KW       = 8,
    parameter int VW       = scp_pkg::DEF_VALUE_BITS,
    parameter int AW       = 7,
    parameter int CW       = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic [scp_pkg::REQ_W-1:0] i_op,
    input  logic [KW-1:0]          i_row,
    input  logic [KW-1:0]          i_col,
    input  logic [VW-1:0]          i_val,
    input  logic                   i_oob,
    output scp_pkg::t_resp         o_resp,
    output logic [VW-1:0]          o_found,
    output logic [CW-1:0]          o_count,
    output logic                   o_rd_en,
    output logic [AW-1:0]          o_rd_addr,
    input  logic [2*KW+VW-1:0]     i_rd_data,
    output logic                   o_wr_en,
    output logic [AW-1:0]          o_wr_addr,
    output logic [2*KW+VW-1:0]     o_wr_data
);

    scp_pkg::t_state        r_state, n_state;
    logic [scp_pkg::REQ_W-1:0] r_op, n_op;
    logic [KW-1:0]          r_row, n_row;
    logic [KW-1:0]          r_col, n_col;
    logic [VW-1:0]          r_val, n_val;
    logic [CW-1:0]          r_count, n_count;
    logic [CW-1:0]          r_idx, n_idx;
    logic                   r_pend, n_pend;
    logic [CW-1:0]          r_pend_idx, n_pend_idx;
    logic                   r_done, n_done;
    scp_pkg::t_status       r_status, n_status;
    logic [VW-1:0]          r_found, n_found;

    logic          w_match;
    logic          w_last;
    logic          w_hit;
    logic          w_miss;
    logic          w_issue;
    logic          w_shift_end;
    logic [CW-1:0] w_prev_idx;

    assign w_match     = (i_rd_data[2*KW+VW-1 -: KW] == r_row)
                      && (i_rd_data[VW +: KW] == r_col);
    assign w_last      = (r_pend_idx == r_count - CW'(1));
    assign w_hit       = r_pend && w_match;
    assign w_miss      = (r_count == '0) || (r_pend && !w_match && w_last);
    assign w_issue     = (r_idx < r_count);
    assign w_shift_end = !r_pend && !w_issue;
    assign w_prev_idx  = r_pend_idx - CW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            scp_pkg::S_IDLE: begin
                if (i_start && !i_oob) begin
                    n_state = scp_pkg::S_SCAN;
                end
            end
            scp_pkg::S_SCAN: begin
                if (w_hit) begin
                    n_state = (r_op == scp_pkg::REQ_REMOVE) ? scp_pkg::S_SHIFT
                                                            : scp_pkg::S_IDLE;
                end else if (w_miss) begin
                    n_state = scp_pkg::S_IDLE;
                end
            end
            scp_pkg::S_SHIFT: begin
                if (w_shift_end) begin
                    n_state = scp_pkg::S_IDLE;
                end
            end
            default: n_state = scp_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_op       = r_op;
        n_row      = r_row;
        n_col      = r_col;
        n_val      = r_val;
        n_count    = r_count;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_done     = 1'b0;
        n_status   = r_status;
        n_found    = r_found;
        o_rd_en    = 1'b0;
        o_rd_addr  = r_idx[AW-1:0];
        o_wr_en    = 1'b0;
        o_wr_addr  = r_pend_idx[AW-1:0];
        o_wr_data  = {r_row, r_col, r_val};
        case (r_state)
            scp_pkg::S_IDLE: begin
                if (i_start) begin
                    n_op   = i_op;
                    n_row  = i_row;
                    n_col  = i_col;
                    n_val  = i_val;
                    n_idx  = '0;
                    n_pend = 1'b0;
                    if (i_oob) begin
                        n_done   = 1'b1;
                        n_status = scp_pkg::ST_BOUNDS;
                        n_found  = '0;
                    end
                end
            end
            scp_pkg::S_SCAN: begin
                if (w_hit) begin
                    case (r_op)
                        scp_pkg::REQ_INSERT: begin
                            o_wr_en  = 1'b1;
                            n_done   = 1'b1;
                            n_status = scp_pkg::ST_UPDATED;
                            n_found  = '0;
                        end
                        scp_pkg::REQ_REMOVE: begin
                            n_idx  = r_pend_idx + CW'(1);
                            n_pend = 1'b0;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_status = scp_pkg::ST_FOUND;
                            n_found  = i_rd_data[VW-1:0];
                        end
                    endcase
                end else if (w_miss) begin
                    n_done  = 1'b1;
                    n_found = '0;
                    n_pend  = 1'b0;
                    case (r_op)
                        scp_pkg::REQ_INSERT: begin
                            if (r_count < CW'(CAPACITY)) begin
                                o_wr_en   = 1'b1;
                                o_wr_addr = r_count[AW-1:0];
                                n_count   = r_count + CW'(1);
                                n_status  = scp_pkg::ST_ADDED;
                            end else begin
                                n_status  = scp_pkg::ST_FULL;
                            end
                        end
                        scp_pkg::REQ_REMOVE: n_status = scp_pkg::ST_ABSENT;
                        default:             n_status = scp_pkg::ST_EMPTY;
                    endcase
                end else if (w_issue) begin
                    o_rd_en    = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx;
                    n_idx      = r_idx + CW'(1);
                end else begin
                    n_pend = 1'b0;
                end
            end
            scp_pkg::S_SHIFT: begin
                // entry k+1 arrives and lands in slot k
                if (r_pend) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = w_prev_idx[AW-1:0];
                    o_wr_data = i_rd_data;
                end
                if (w_issue) begin
                    o_rd_en    = 1'b1;
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx;
                    n_idx      = r_idx + CW'(1);
                end else begin
                    n_pend = 1'b0;
                end
                if (w_shift_end) begin
                    n_count  = r_count - CW'(1);
                    n_done   = 1'b1;
                    n_status = scp_pkg::ST_REMOVED;
                    n_found  = '0;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= scp_pkg::S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_row      <= n_row;
        r_col      <= n_col;
        r_val      <= n_val;
        r_pend_idx <= n_pend_idx;
        r_status   <= n_status;
        r_found    <= n_found;
    end

    assign o_busy        = (r_state != scp_pkg::S_IDLE);
    assign o_resp.done   = r_done;
    assign o_resp.status = r_status;
    assign o_found       = r_found;
    assign o_count       = r_count;

endmodule
